[hdl/b64dec_pkg.sv]
// b64dec_pkg: payload types, result codes and character map for the
// base64 stream decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64dec_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } b64dec_in_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    logic [1:0] status_code;
    logic       run_last;
  } b64dec_out_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;

  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic       ok;
    logic [5:0] sextet;
  } b64dec_map_t;

  // Sextet for one character; ok is low for a character outside the alphabet.
  function automatic b64dec_map_t b64dec_map(input logic [7:0] c);
    b64dec_map_t m;
    logic [7:0]  v;
    m = '{ok: 1'b1, sextet: 6'd0};
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == CH_PLUS) begin
      v = 8'd62;
    end else if (c == CH_SLASH) begin
      v = 8'd63;
    end else if (c == CH_PAD) begin
      v = 8'd0;
    end else begin
      m.ok = 1'b0;
    end
    m.sextet = v[5:0];
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/base64_stream_decoder.sv]
// base64_stream_decoder: streaming base64 text decoder, top level.
// Depends on b64dec_pkg.
//
// Usage:
//   in_*  : one text character per transfer; end_of_text marks the last one.
//   out_* : decoded bytes (item_kind 0), then one status item (item_kind 1)
//           after the end character. run_last flags the last result that a
//           character causes. Status 0 ok, 1 invalid character, 2 length not
//           a multiple of four. Drop the text's bytes when the status is not 0.
//   After an invalid character no further bytes come out of that text.
// Timing:
//   A character is registered on transfer and decoded into the result
//   buffer once that is free. Characters that cause no result go at 1 per
//   cycle while the buffer is free; one that causes N results holds it until
//   all are taken, one result per cycle on the output port while out_ready
//   is high; that port sets the rate (3 bytes per group).
//   The input register takes a new character while a result waits.
// Reset: rst_n (synchronous) clears the group state and empties both stages.
// Stall: out_ready low holds the current result; once the input register
//   is also full, in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder
  import b64dec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire b64dec_in_t  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output b64dec_out_t      out_data
);

  // input register
  logic        itm_vld_r;
  b64dec_in_t  itm_r;

  // group state
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        pad3_r, pad3_nxt;
  logic        sticky_r, sticky_nxt;

  // result buffer
  logic        bst_vld_r;
  logic [23:0] bst_word_r, bst_word_nxt;
  logic [1:0]  bst_nb_r, bst_nb_nxt;
  logic        bst_end_r, bst_end_nxt;
  logic [1:0]  bst_st_r, bst_st_nxt;
  logic [1:0]  bst_idx_r;

  b64dec_map_t map;
  logic        is_pad;
  logic        cur_data;
  logic        cur_last;
  logic        pop;
  logic        bst_free;
  logic        proc;
  logic        has_res;

  assign map    = b64dec_map(itm_r.char_code);
  assign is_pad = (itm_r.char_code == CH_PAD);

  assign cur_data = (bst_idx_r < bst_nb_r);
  assign cur_last = cur_data ? (!bst_end_r && bst_idx_r == bst_nb_r - 2'd1) : 1'b1;
  assign pop      = out_valid && out_ready;
  assign bst_free = !bst_vld_r || (pop && cur_last);
  assign proc     = itm_vld_r && bst_free;
  assign in_ready = !itm_vld_r || proc;

  always_comb begin
    sticky_nxt   = sticky_r | ~map.ok;
    bst_word_nxt = {acc_r, map.ok ? map.sextet : 6'd0};
    bst_end_nxt  = itm_r.end_of_text;
    bst_nb_nxt   = 2'd0;
    acc_nxt      = acc_r;
    pos_nxt      = pos_r;
    pad3_nxt     = pad3_r;
    if (pos_r == 2'd3) begin
      if (!sticky_nxt) begin
        if (!itm_r.end_of_text) begin
          bst_nb_nxt = 2'd3;
        end else if (pad3_r) begin
          bst_nb_nxt = 2'd1;
        end else if (is_pad) begin
          bst_nb_nxt = 2'd2;
        end else begin
          bst_nb_nxt = 2'd3;
        end
      end
      acc_nxt  = 18'd0;
      pos_nxt  = 2'd0;
      pad3_nxt = 1'b0;
    end else begin
      if (pos_r == 2'd2 && is_pad) begin
        pad3_nxt = 1'b1;
      end
      acc_nxt = bst_word_nxt[17:0];
      pos_nxt = pos_r + 2'd1;
    end
    if (sticky_nxt) begin
      bst_st_nxt = ST_INVALID;
    end else if (pos_r != 2'd3) begin
      bst_st_nxt = ST_LENGTH;
    end else begin
      bst_st_nxt = ST_OK;
    end
    has_res = (bst_nb_nxt != 2'd0) || itm_r.end_of_text;
    if (itm_r.end_of_text) begin
      acc_nxt    = 18'd0;
      pos_nxt    = 2'd0;
      pad3_nxt   = 1'b0;
      sticky_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itm_vld_r <= 1'b0;
      acc_r     <= 18'd0;
      pos_r     <= 2'd0;
      pad3_r    <= 1'b0;
      sticky_r  <= 1'b0;
      bst_vld_r <= 1'b0;
      bst_idx_r <= 2'd0;
    end else begin
      if (in_ready) begin
        itm_vld_r <= in_valid;
      end
      if (proc) begin
        acc_r     <= acc_nxt;
        pos_r     <= pos_nxt;
        pad3_r    <= pad3_nxt;
        sticky_r  <= sticky_nxt;
        bst_vld_r <= has_res;
        bst_idx_r <= 2'd0;
      end else if (pop) begin
        if (cur_last) begin
          bst_vld_r <= 1'b0;
        end
        bst_idx_r <= bst_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      itm_r <= in_data;
    end
    if (proc) begin
      bst_word_r <= bst_word_nxt;
      bst_nb_r   <= bst_nb_nxt;
      bst_end_r  <= bst_end_nxt;
      bst_st_r   <= bst_st_nxt;
    end
  end

  always_comb begin
    out_valid = bst_vld_r;
    if (cur_data) begin
      out_data.item_kind   = KIND_DATA;
      out_data.data_byte   = bst_word_r[23 - 8 * bst_idx_r -: 8];
      out_data.status_code = ST_OK;
    end else begin
      out_data.item_kind   = KIND_STATUS;
      out_data.data_byte   = 8'd0;
      out_data.status_code = bst_st_r;
    end
    out_data.run_last = cur_last;
  end

  // status item always closes the results of its character
  a_status_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_STATUS |-> out_data.run_last)
    else $error("status item without run_last");

  // a held character stays held until the result buffer frees
  a_item_hold : assert property (@(posedge clk) disable iff (!rst_n)
    itm_vld_r && !proc |=> itm_vld_r && $stable(itm_r))
    else $error("held character lost");

  // a stalled result does not change
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // at most three data bytes per character
  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_DATA |-> bst_idx_r != 2'd3)
    else $error("data index out of range");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// tb_top: self-checking testbench for base64_stream_decoder.
// Depends on b64dec_pkg and the decoder RTL. Directed characters, then random
// texts are sent; each result is checked against the table or a local decoder.
`timescale 1ns / 1ps

module tb_top;
  import b64dec_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [1:0] nbytes;
    logic [7:0] byte_val;
    logic [1:0] status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  b64dec_in_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  b64dec_out_t out_data;

  // decoder state for the text in flight
  logic [17:0] grp_acc = '0;
  logic [1:0]  grp_pos = '0;
  logic        grp_third_pad = 1'b0;
  logic [1:0]  text_status = ST_OK;

  b64dec_out_t expected_q[$];
  int          mismatch_cnt = 0;
  int          sent_cnt = 0;
  int          send_pct = 0;
  int          recv_pct = 0;

  dir_row_t dir_rows [25] = '{
    '{"A",   1'b1, 1'b1, 2'd0, 8'h00, ST_LENGTH},
    '{"!",   1'b1, 1'b1, 2'd0, 8'h00, ST_INVALID},
    '{"A",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"A",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"A",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"A",   1'b1, 1'b1, 2'd3, 8'h00, ST_OK},
    '{"/",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"/",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"/",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"/",   1'b1, 1'b1, 2'd3, 8'hFF, ST_OK},
    '{"T",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"W",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"E",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"=",   1'b1, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"T",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"Q",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"=",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"=",   1'b1, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"+",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"=",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"0",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{"9",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{8'hFF, 1'b1, 1'b1, 2'd0, 8'h00, ST_INVALID},
    '{"z",   1'b0, 1'b0, 2'd0, 8'h00, ST_OK},
    '{8'h00, 1'b1, 1'b1, 2'd0, 8'h00, ST_INVALID}
  };

  base64_stream_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Append one expected result to the scoreboard.
  function automatic void queue_expect(input b64dec_out_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Decode one accepted character; queue its results when keep is set.
  function automatic void decode_char(input b64dec_in_t c, input bit keep);
    logic [7:0]  ch;
    logic [5:0]  sx;
    logic        pad;
    logic [23:0] word;
    logic [7:0]  by [3];
    logic [1:0]  st;
    int          nb;
    ch = c.char_code;
    pad = (ch == CH_PAD);
    nb = 0;
    sx = '0;
    if (ch >= "A" && ch <= "Z") begin
      sx = 6'(ch - "A");
    end else if (ch >= "a" && ch <= "z") begin
      sx = 6'(ch - "a" + 8'd26);
    end else if (ch >= "0" && ch <= "9") begin
      sx = 6'(ch - "0" + 8'd52);
    end else if (ch == CH_PLUS) begin
      sx = 6'd62;
    end else if (ch == CH_SLASH) begin
      sx = 6'd63;
    end else if (!pad) begin
      text_status = ST_INVALID;
    end
    word = {grp_acc, sx};
    by[0] = word[23:16];
    by[1] = word[15:8];
    by[2] = word[7:0];
    if (grp_pos == 2'd3) begin
      if (text_status == ST_OK) begin
        if (!c.end_of_text) nb = 3;
        else if (grp_third_pad) nb = 1;
        else if (pad) nb = 2;
        else nb = 3;
      end
      grp_acc = '0;
      grp_pos = '0;
      grp_third_pad = 1'b0;
    end else begin
      if (grp_pos == 2'd2 && pad) grp_third_pad = 1'b1;
      grp_acc = {grp_acc[11:0], sx};
      grp_pos = grp_pos + 2'd1;
    end
    for (int i = 0; i < nb; i++) begin
      if (keep) begin
        queue_expect('{KIND_DATA, by[i], ST_OK, !c.end_of_text && i == nb - 1});
      end
    end
    if (c.end_of_text) begin
      st = text_status;
      if (st == ST_OK && grp_pos != 2'd0) st = ST_LENGTH;
      if (keep) queue_expect('{KIND_STATUS, 8'h00, st, 1'b1});
      grp_acc = '0;
      grp_pos = '0;
      grp_third_pad = 1'b0;
      text_status = ST_OK;
    end
  endfunction

  // Present one character, hold it until the transfer, then predict.
  task automatic send_char(input b64dec_in_t d, input bit keep);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    decode_char(d, keep);
  endtask

  function automatic logic [7:0] pick_b64_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    if (r == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  // One random text: mostly well-formed, some with junk, odd padding or cut short.
  task automatic send_text();
    logic [7:0] txt[$];
    int         mode;
    int         ngrp;
    int         len;
    mode = $urandom_range(0, 99);
    ngrp = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    if (mode < 4) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < 4 * ngrp; i++) txt.insert(txt.size(), pick_b64_char());
      case ($urandom_range(0, 2))
        1: txt[txt.size() - 1] = CH_PAD;
        2: begin
          txt[txt.size() - 1] = CH_PAD;
          txt[txt.size() - 2] = CH_PAD;
        end
        default: ;
      endcase
      if (mode < 19) begin
        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (mode < 29) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len && txt.size() > 1; i++) void'(txt.pop_back());
      end else if (mode < 36) begin
        txt[$urandom_range(0, txt.size() - 1)] = CH_PAD;
      end
    end
    foreach (txt[i]) begin
      send_char('{char_code: txt[i], end_of_text: i == txt.size() - 1}, 1'b1);
    end
  endtask

  task automatic check_result(input b64dec_out_t got);
    b64dec_out_t exp;
    if (expected_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("unexpected result: kind=%0d data=%02h status=%0d last=%0d",
                 got.item_kind, got.data_byte, got.status_code, got.run_last);
      end
    end else begin
      exp = expected_q.pop_front();
      if (got.item_kind !== exp.item_kind || got.data_byte !== exp.data_byte ||
          got.status_code !== exp.status_code || got.run_last !== exp.run_last) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("mismatch: exp kind=%0d data=%02h status=%0d last=%0d,",
                   exp.item_kind, exp.data_byte, exp.status_code, exp.run_last,
                   " got kind=%0d data=%02h status=%0d last=%0d",
                   got.item_kind, got.data_byte, got.status_code, got.run_last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    out_ready <= ($urandom_range(0, 99) >= recv_pct);
  end

  initial begin
    b64dec_in_t d;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      d = '{char_code: dir_rows[i].ch, end_of_text: dir_rows[i].eot};
      send_char(d, !dir_rows[i].typed);
      if (dir_rows[i].typed) begin
        for (int k = 0; k < dir_rows[i].nbytes; k++) begin
          queue_expect('{KIND_DATA, dir_rows[i].byte_val, ST_OK,
                         !dir_rows[i].eot && k == dir_rows[i].nbytes - 1});
        end
        if (dir_rows[i].eot) begin
          queue_expect('{KIND_STATUS, 8'h00, dir_rows[i].status, 1'b1});
        end
      end
    end

    // idle mix per phase: none, sender only, receiver only, both
    for (int ph = 0; ph < 4; ph++) begin
      send_pct = (ph == 1) ? 54 : (ph == 3) ? 28 : 0;
      recv_pct = (ph == 2) ? 54 : (ph == 3) ? 28 : 0;
      while (sent_cnt < 25 + 59 * (ph + 1)) send_text();
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
